### rtl/dqe_pkg.sv
// Shared types and constants for the double-ended queue with erase by value.
package dqe_pkg;

   localparam int DEPTH_DEF   = 64;
   localparam int DATA_W      = 32;
   localparam int OP_W        = 3;
   localparam int STS_W       = 2;
   localparam int CNT_FIELD_W = 7;

   // Request codes
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = OP_W'(0);
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = OP_W'(1);
   localparam logic [OP_W-1:0] OP_POP_FRONT  = OP_W'(2);
   localparam logic [OP_W-1:0] OP_POP_BACK   = OP_W'(3);
   localparam logic [OP_W-1:0] OP_ERASE      = OP_W'(4);

   // Result status codes
   localparam logic [STS_W-1:0] STS_OK        = STS_W'(0);
   localparam logic [STS_W-1:0] STS_UNDERFLOW = STS_W'(1);
   localparam logic [STS_W-1:0] STS_OVERFLOW  = STS_W'(2);

   typedef struct packed {
      logic [OP_W-1:0]          req_type;
      logic signed [DATA_W-1:0] value;
   } dqe_req_item_type;

   typedef struct packed {
      logic [STS_W-1:0]         status;
      logic [CNT_FIELD_W-1:0]   occupancy;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] back_value;
      logic                     is_empty;
      logic [CNT_FIELD_W-1:0]   removed_count;
   } dqe_rsp_item_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic exec;
      logic fetch;
      logic walk;
      logic load_rsp;
   } dqe_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_fetch;
      logic need_walk;
      logic walk_last;
   } dqe_stat_type;

endpackage

### rtl/deque_with_erase_by_value.sv
// Top level of the bounded double-ended queue with erase by value.
// A bounded double-ended queue of signed 32-bit values held in a ring memory of
// DEPTH entries. Each request transaction pushes at the front or back, pops from
// the front or back, or erases every entry equal to the given value while keeping
// the order of the rest; each gives exactly one result transaction describing the
// queue afterwards (status, occupancy, front and back values, empty flag, removed
// count). One request is worked on at a time; the result sits in an output
// register, so the next request is taken while it waits. Pushes, failed requests
// and unused codes finish in the execute step; a pop that leaves entries behind
// adds a fetch step, since the new end value comes from one read of the ring
// memory; an erase adds a walk that reads and repacks one entry per cycle
// through the memory's one read port and one write port. The result is valid in
// the cycle after the last working cycle, or later while the previous result
// waits. The ring needs no clearing after reset.
module deque_with_erase_by_value #(
   parameter int DEPTH = dqe_pkg::DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  dqe_pkg::dqe_req_item_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output dqe_pkg::dqe_rsp_item_type rsp_data
);
   import dqe_pkg::*;

   dqe_cmd_type  cmd;
   dqe_stat_type stat;

   // Sequencer: accept, execute, optional end-value fetch or erase walk, result load
   dqe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Ring memory, pointers, cached end values and result register
   dqe_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .stat     (stat)
   );
endmodule

### rtl/dqe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dqe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/dqe_ctrl.sv
// Sequencing state machine and result-valid register for the queue.
module dqe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  dqe_pkg::dqe_stat_type stat,
   output dqe_pkg::dqe_cmd_type  cmd
);
   import dqe_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FETCH,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      logic done;
      logic out_free;
      done         = 1'b0;
      out_free     = !rsp_valid_ff || rsp_ready;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.need_fetch) begin
               state_in = ST_FETCH;
            end else if (stat.need_walk) begin
               state_in = ST_WALK;
            end else begin
               done = 1'b1;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            done      = 1'b1;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            done     = stat.walk_last;
         end
         ST_FINISH: begin
            done = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (done) begin
         if (out_free) begin
            cmd.load_rsp = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            state_in = ST_FINISH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

### rtl/dqe_dp.sv
// Ring storage, pointers, end-value registers and result register of the queue.
module dqe_dp #(
   parameter int DEPTH = dqe_pkg::DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dqe_pkg::dqe_req_item_type req_data,
   output dqe_pkg::dqe_rsp_item_type rsp_data,
   input  dqe_pkg::dqe_cmd_type      cmd,
   output dqe_pkg::dqe_stat_type     stat
);
   import dqe_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   // Ring position ofs entries after base; ofs never exceeds DEPTH
   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] ofs);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(ofs);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return AW'(sum);
   endfunction

   function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] base);
      return (base == '0) ? LAST_IDX : base - AW'(1);
   endfunction

   logic [OP_W-1:0]   op_ff, op_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [AW-1:0]     front_ff, front_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [DATA_W-1:0] front_val_ff, front_val_in;
   logic [DATA_W-1:0] back_val_ff, back_val_in;
   logic [STS_W-1:0]  status_ff, status_in;
   logic [CW-1:0]     removed_ff, removed_in;
   logic [CW-1:0]     rd_ofs_ff, rd_ofs_in;
   logic [CW-1:0]     kept_ff, kept_in;
   dqe_rsp_item_type  rsp_ff, rsp_in;

   logic              ram_we;
   logic [AW-1:0]     ram_wa;
   logic [DATA_W-1:0] ram_wd;
   logic [AW-1:0]     ram_ra;
   logic [DATA_W-1:0] ram_rd;

   dqe_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   always_comb begin
      logic [CW-1:0] cnt_dec;
      logic          now_empty;
      cnt_dec      = count_ff - CW'(1);
      op_in        = op_ff;
      val_in       = val_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      front_val_in = front_val_ff;
      back_val_in  = back_val_ff;
      status_in    = status_ff;
      removed_in   = removed_ff;
      rd_ofs_in    = rd_ofs_ff;
      kept_in      = kept_ff;
      ram_we       = 1'b0;
      ram_wa       = front_ff;
      ram_wd       = val_ff;
      ram_ra       = front_ff;
      stat         = '0;

      if (cmd.accept) begin
         op_in  = req_data.req_type;
         val_in = req_data.value;
      end

      if (cmd.exec) begin
         status_in  = STS_OK;
         removed_in = '0;
         case (op_ff)
            OP_PUSH_FRONT: begin
               if (count_ff == FULL_CNT) begin
                  status_in = STS_OVERFLOW;
               end else begin
                  front_in     = ring_dec(front_ff);
                  ram_we       = 1'b1;
                  ram_wa       = front_in;
                  front_val_in = val_ff;
                  if (count_ff == '0) begin
                     back_val_in = val_ff;
                  end
                  count_in = count_ff + CW'(1);
               end
            end
            OP_PUSH_BACK: begin
               if (count_ff == FULL_CNT) begin
                  status_in = STS_OVERFLOW;
               end else begin
                  ram_we      = 1'b1;
                  ram_wa      = ring_add(front_ff, count_ff);
                  back_val_in = val_ff;
                  if (count_ff == '0) begin
                     front_val_in = val_ff;
                  end
                  count_in = count_ff + CW'(1);
               end
            end
            OP_POP_FRONT: begin
               if (count_ff == '0) begin
                  status_in = STS_UNDERFLOW;
               end else begin
                  front_in        = ring_add(front_ff, CW'(1));
                  count_in        = cnt_dec;
                  removed_in      = CW'(1);
                  ram_ra          = front_in;
                  stat.need_fetch = (cnt_dec != '0);
               end
            end
            OP_POP_BACK: begin
               if (count_ff == '0) begin
                  status_in = STS_UNDERFLOW;
               end else begin
                  count_in        = cnt_dec;
                  removed_in      = CW'(1);
                  ram_ra          = ring_add(front_ff, cnt_dec - CW'(1));
                  stat.need_fetch = (cnt_dec != '0);
               end
            end
            OP_ERASE: begin
               if (count_ff == '0) begin
                  status_in = STS_UNDERFLOW;
               end else begin
                  ram_ra         = front_ff;
                  rd_ofs_in      = CW'(1);
                  kept_in        = '0;
                  stat.need_walk = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // New end value after a pop
      if (cmd.fetch) begin
         if (op_ff == OP_POP_FRONT) begin
            front_val_in = ram_rd;
         end else begin
            back_val_in = ram_rd;
         end
      end

      // Erase walk: one entry checked per cycle, survivors packed toward the front
      if (cmd.walk) begin
         if (ram_rd != val_ff) begin
            ram_we = 1'b1;
            ram_wa = ring_add(front_ff, kept_ff);
            ram_wd = ram_rd;
            if (kept_ff == '0) begin
               front_val_in = ram_rd;
            end
            back_val_in = ram_rd;
            kept_in     = kept_ff + CW'(1);
         end
         ram_ra         = ring_add(front_ff, rd_ofs_ff);
         rd_ofs_in      = rd_ofs_ff + CW'(1);
         stat.walk_last = (rd_ofs_ff == count_ff);
         if (stat.walk_last) begin
            count_in   = kept_in;
            removed_in = count_ff - kept_in;
         end
      end

      now_empty            = (count_in == '0);
      rsp_in.status        = status_in;
      rsp_in.occupancy     = CNT_FIELD_W'(count_in);
      rsp_in.front_value   = now_empty ? '0 : front_val_in;
      rsp_in.back_value    = now_empty ? '0 : back_val_in;
      rsp_in.is_empty      = now_empty;
      rsp_in.removed_count = CNT_FIELD_W'(removed_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
      op_ff        <= op_in;
      val_ff       <= val_in;
      front_val_ff <= front_val_in;
      back_val_ff  <= back_val_in;
      status_ff    <= status_in;
      removed_ff   <= removed_in;
      rd_ofs_ff    <= rd_ofs_in;
      kept_ff      <= kept_in;
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;
endmodule

### rtl/dqe_checker.sv
// Port-level checks on the queue's handshakes and results, bound to the top level.
module dqe_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input dqe_pkg::dqe_rsp_item_type rsp_data
);
   import dqe_pkg::*;

   // Requests taken whose result has not yet been delivered
   logic [1:0] outst_ff, outst_in;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      outst_in = outst_ff + 2'(req_acc) - 2'(rsp_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else begin
         outst_ff <= outst_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> outst_ff != 2'd0)
      else $error("result transaction without a pending request");

   a_two_deep: assert property (@(posedge clock) disable iff (reset)
      outst_ff == 2'd2 |-> !req_ready)
      else $error("request taken with one in progress and one waiting");

   a_fail_removes_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STS_OK |-> rsp_data.removed_count == '0)
      else $error("failed request reports removed entries");

endmodule

bind deque_with_erase_by_value dqe_checker u_dqe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### sim/deque_with_erase_by_value_test.sv
// Self-checking testbench for the bounded double-ended queue with erase by value.
`timescale 1ns / 1ps

module deque_with_erase_by_value_test;
   import dqe_pkg::*;

   localparam int DEPTH        = DEPTH_DEF;
   localparam int PTR_W        = $clog2(DEPTH);
   localparam int RANDOM_OPS   = 1040;     // random requests that do real work
   localparam int HOLD_AT      = 200;      // transaction count that starts the long hold-off
   localparam int HOLD_CYCLES  = 300;
   localparam int STEADY_FROM  = 500;      // window with no idling on either side
   localparam int STEADY_TO    = 700;
   localparam int DRAIN_CYCLES = 100;
   localparam int LIMIT_CYCLES = 400000;

   // Request codes the block must treat as no operation
   localparam logic [OP_W-1:0] OP_UNUSED_FIRST = OP_W'(5);
   localparam logic [OP_W-1:0] OP_UNUSED_LAST  = OP_W'(7);

   localparam logic [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;

   // One row of stimulus: the request, and optionally a hand-written result
   typedef struct packed {
      dqe_req_item_type req;
      logic             typed;
      dqe_rsp_item_type rsp;
   } stim_row_type;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   dqe_req_item_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   dqe_rsp_item_type rsp_data;

   deque_with_erase_by_value uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shadow deque: our own copy of the ring, its front position and fill
   // ---------------------------------------------------------------------
   logic [DATA_W-1:0]      ring_mem [DEPTH];
   logic [PTR_W-1:0]       head_pos = '0;
   logic [CNT_FIELD_W-1:0] held     = '0;

   dqe_rsp_item_type pending_rsps [$];   // results still owed by the block
   stim_row_type     directed_rows [$];
   stim_row_type     stim_rows [$];

   int sent_count = 0;
   int got_count  = 0;
   int mismatches = 0;
   int cycle_count = 0;

   // tallies for the closing summary
   int n_push = 0, n_pop = 0, n_erase = 0, n_unused = 0;
   int n_overflow = 0, n_underflow = 0, n_removed = 0, peak_held = 0;

   // ring position lying ofs entries behind the front
   function automatic logic [PTR_W-1:0] slot(logic [CNT_FIELD_W-1:0] ofs);
      return head_pos + ofs[PTR_W-1:0];
   endfunction

   // append helpers for the stimulus tables
   function automatic void dir_add(stim_row_type r);
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   function automatic void stim_add(stim_row_type r);
      stim_rows.insert(stim_rows.size(), r);
   endfunction

   // Applies one request to the shadow deque and returns the result it owes
   function automatic dqe_rsp_item_type apply_request(dqe_req_item_type rq);
      dqe_rsp_item_type       r;
      logic [CNT_FIELD_W-1:0] kept;
      logic [DATA_W-1:0]      e;
      int                     i;
      r = '0;
      r.status = STS_OK;
      case (rq.req_type)
         OP_PUSH_FRONT: begin
            if (held == DEPTH) begin
               r.status = STS_OVERFLOW;
            end else begin
               head_pos = head_pos - PTR_W'(1);
               ring_mem[head_pos] = rq.value;
               held++;
            end
         end
         OP_PUSH_BACK: begin
            if (held == DEPTH) begin
               r.status = STS_OVERFLOW;
            end else begin
               ring_mem[slot(held)] = rq.value;
               held++;
            end
         end
         OP_POP_FRONT: begin
            if (held == 0) begin
               r.status = STS_UNDERFLOW;
            end else begin
               head_pos = head_pos + PTR_W'(1);
               held--;
               r.removed_count = CNT_FIELD_W'(1);
            end
         end
         OP_POP_BACK: begin
            if (held == 0) begin
               r.status = STS_UNDERFLOW;
            end else begin
               held--;
               r.removed_count = CNT_FIELD_W'(1);
            end
         end
         OP_ERASE: begin
            if (held == 0) begin
               r.status = STS_UNDERFLOW;
            end else begin
               // compact survivors toward the front, order kept
               kept = '0;
               for (i = 0; i < held; i++) begin
                  e = ring_mem[slot(CNT_FIELD_W'(i))];
                  if (e != rq.value) begin
                     ring_mem[slot(kept)] = e;
                     kept++;
                  end
               end
               r.removed_count = held - kept;
               held = kept;
            end
         end
         default: ;   // unused code: nothing moves
      endcase
      r.occupancy = held;
      r.is_empty  = (held == 0);
      if (held != 0) begin
         r.front_value = ring_mem[head_pos];
         r.back_value  = ring_mem[slot(held - CNT_FIELD_W'(1))];
      end
      return r;
   endfunction

   function automatic stim_row_type mk_row(logic [OP_W-1:0] op, logic [DATA_W-1:0] val,
                                           logic typed, logic [STS_W-1:0] sts,
                                           int occ, logic [DATA_W-1:0] fv,
                                           logic [DATA_W-1:0] bv, logic empty, int rem);
      stim_row_type row;
      row = '0;
      row.req.req_type      = op;
      row.req.value         = val;
      row.typed             = typed;
      row.rsp.status        = sts;
      row.rsp.occupancy     = CNT_FIELD_W'(occ);
      row.rsp.front_value   = fv;
      row.rsp.back_value    = bv;
      row.rsp.is_empty      = empty;
      row.rsp.removed_count = CNT_FIELD_W'(rem);
      return row;
   endfunction

   // values that repeat often, so erase finds plenty to remove
   function automatic logic [DATA_W-1:0] pool_value(int k);
      case (k)
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return 32'h0000_0001;
         3:       return 32'h0000_0007;
         4:       return VAL_MAX;
         default: return VAL_MIN;
      endcase
   endfunction

   // Runs the predictor on an accepted request and queues what comes back
   task automatic log_request(stim_row_type row);
      dqe_rsp_item_type predicted;
      predicted = apply_request(row.req);
      case (row.req.req_type)
         OP_PUSH_FRONT, OP_PUSH_BACK: n_push++;
         OP_POP_FRONT, OP_POP_BACK:   n_pop++;
         OP_ERASE:                    n_erase++;
         default:                     n_unused++;
      endcase
      if (predicted.status == STS_OVERFLOW)  n_overflow++;
      if (predicted.status == STS_UNDERFLOW) n_underflow++;
      n_removed += int'(predicted.removed_count);
      if (predicted.occupancy > peak_held) peak_held = int'(predicted.occupancy);
      // a hand-written row is trusted over the predictor
      pending_rsps.insert(pending_rsps.size(), row.typed ? row.rsp : predicted);
   endtask

   task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on result %0d, %s: expected %0h, got %0h",
                     got_count, name, want, got);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sender: walks stim_rows, idles at random, holds each transaction
   // steady until the block takes it
   // ---------------------------------------------------------------------
   int           next_row = 0;
   stim_row_type cur_row;
   wire          steady = (sent_count >= STEADY_FROM) && (sent_count < STEADY_TO);

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         sent_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            log_request(cur_row);
            sent_count <= sent_count + 1;
         end
         if (!req_valid || req_ready) begin
            if (next_row < stim_rows.size() && (steady || $urandom_range(0, 99) >= 16)) begin
               cur_row = stim_rows[next_row];
               next_row++;
               req_valid <= 1'b1;
               req_data  <= cur_row.req;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random back-pressure, plus one long hold-off so the result
   // register stays full and the block stalls its request side
   // ---------------------------------------------------------------------
   int   hold_left = 0;
   logic hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && sent_count >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(0, 99) >= 16);
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: every accepted result against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      dqe_rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d arrived with nothing outstanding", got_count);
         end else begin
            want = pending_rsps[0];
            pending_rsps.delete(0);
            check_field("status",        DATA_W'(want.status),        DATA_W'(rsp_data.status));
            check_field("occupancy",     DATA_W'(want.occupancy),
                        DATA_W'(rsp_data.occupancy));
            check_field("front_value",   want.front_value,            rsp_data.front_value);
            check_field("back_value",    want.back_value,             rsp_data.back_value);
            check_field("is_empty",      DATA_W'(want.is_empty),      DATA_W'(rsp_data.is_empty));
            check_field("removed_count", DATA_W'(want.removed_count),
                        DATA_W'(rsp_data.removed_count));
         end
         got_count++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timed out with %0d results outstanding", pending_rsps.size());
         $display("deque_with_erase_by_value_test: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus build, reset and end of run
   // ---------------------------------------------------------------------
   initial begin : main_flow
      stim_row_type     row;
      logic [OP_W-1:0]  op;
      logic [DATA_W-1:0] val;
      int               ops_made, n, k, seg, mode, roll;

      // Directed table. Rows with typed=1 carry their result; the rest rely on
      // the shadow deque.
      //             op               value         t  status         occ front    back   e rem
      dir_add(mk_row(OP_POP_FRONT,    32'h0,        1, STS_UNDERFLOW, 0, 32'h0,   32'h0,  1, 0));
      dir_add(mk_row(OP_POP_BACK,     32'h0,        1, STS_UNDERFLOW, 0, 32'h0,   32'h0,  1, 0));
      dir_add(mk_row(OP_ERASE,        32'h5,        1, STS_UNDERFLOW, 0, 32'h0,   32'h0,  1, 0));
      dir_add(mk_row(OP_UNUSED_FIRST, VAL_MAX,      1, STS_OK,        0, 32'h0,   32'h0,  1, 0));
      dir_add(mk_row(OP_PUSH_BACK,    VAL_MAX,      1, STS_OK,        1, VAL_MAX, VAL_MAX, 0, 0));
      dir_add(mk_row(OP_PUSH_FRONT,   VAL_MIN,      1, STS_OK,        2, VAL_MIN, VAL_MAX, 0, 0));
      dir_add(mk_row(OP_PUSH_BACK,    32'h0,        0, STS_OK,        0, 32'h0,   32'h0,  0, 0));
      dir_add(mk_row(OP_PUSH_FRONT,   32'hffff_ffff, 0, STS_OK,       0, 32'h0,   32'h0,  0, 0));
      // erase that matches nothing
      dir_add(mk_row(OP_ERASE,        32'd12345,    0, STS_OK,        0, 32'h0,   32'h0,  0, 0));
      dir_add(mk_row(OP_PUSH_BACK,    32'hffff_ffff, 0, STS_OK,       0, 32'h0,   32'h0,  0, 0));
      dir_add(mk_row(OP_PUSH_FRONT,   32'h5555_5555, 0, STS_OK,       0, 32'h0,   32'h0,  0, 0));
      // two separated matches, survivors close up
      dir_add(mk_row(OP_ERASE,        32'hffff_ffff, 0, STS_OK,       0, 32'h0,   32'h0,  0, 0));
      dir_add(mk_row(OP_UNUSED_FIRST + OP_W'(1), 32'h0, 0, STS_OK,    0, 32'h0,   32'h0,  0, 0));
      dir_add(mk_row(OP_POP_FRONT,    32'h0,        0, STS_OK,        0, 32'h0,   32'h0,  0, 0));
      dir_add(mk_row(OP_POP_BACK,     32'h0,        0, STS_OK,        0, 32'h0,   32'h0,  0, 0));
      dir_add(mk_row(OP_UNUSED_LAST,  32'hffff_ffff, 0, STS_OK,       0, 32'h0,   32'h0,  0, 0));
      dir_add(mk_row(OP_ERASE,        VAL_MIN,      0, STS_OK,        0, 32'h0,   32'h0,  0, 0));
      // erase that empties the queue
      dir_add(mk_row(OP_ERASE,        VAL_MAX,      1, STS_OK,        0, 32'h0,   32'h0,  1, 1));
      dir_add(mk_row(OP_PUSH_BACK,    32'haaaa_aaaa, 0, STS_OK,       0, 32'h0,   32'h0,  0, 0));
      // pop front of a lone entry
      dir_add(mk_row(OP_POP_FRONT,    32'h0,        1, STS_OK,        0, 32'h0,   32'h0,  1, 1));
      dir_add(mk_row(OP_PUSH_FRONT,   32'h0,        0, STS_OK,        0, 32'h0,   32'h0,  0, 0));
      dir_add(mk_row(OP_POP_BACK,     32'h0,        1, STS_OK,        0, 32'h0,   32'h0,  1, 1));
      dir_add(mk_row(OP_ERASE,        32'h0,        1, STS_UNDERFLOW, 0, 32'h0,   32'h0,  1, 0));
      foreach (directed_rows[i]) stim_add(directed_rows[i]);

      // Random part. Opens with a push-heavy run that must reach overflow,
      // then segments that lean toward filling, draining or a mix.
      row = '0;
      for (n = 0; n < 150; n++) begin
         if ($urandom_range(0, 9) == 0) op = OP_POP_BACK;
         else op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
         row.req.req_type = op;
         row.req.value    = $urandom_range(0, 1) ? pool_value($urandom_range(0, 5)) : $urandom;
         stim_add(row);
      end
      ops_made = 150;
      while (ops_made < RANDOM_OPS) begin
         mode = $urandom_range(0, 2);
         seg  = $urandom_range(30, 120);
         for (k = 0; k < seg && ops_made < RANDOM_OPS; k++) begin
            roll = $urandom_range(0, 99);
            val  = $urandom_range(0, 1) ? pool_value($urandom_range(0, 5)) : $urandom;
            if (roll < 3) begin
               op = OP_UNUSED_FIRST + OP_W'($urandom_range(0, 2));
            end else begin
               roll = $urandom_range(0, 99);
               case (mode)
                  0:       op = (roll < 70) ? OP_PUSH_FRONT : (roll < 88) ? OP_POP_FRONT : OP_ERASE;
                  1:       op = (roll < 25) ? OP_PUSH_FRONT : (roll < 80) ? OP_POP_FRONT : OP_ERASE;
                  default: op = (roll < 45) ? OP_PUSH_FRONT : (roll < 75) ? OP_POP_FRONT : OP_ERASE;
               endcase
               // choose the end at random
               if (op == OP_PUSH_FRONT && $urandom_range(0, 1)) op = OP_PUSH_BACK;
               if (op == OP_POP_FRONT && $urandom_range(0, 1)) op = OP_POP_BACK;
               // erase mostly targets values that recur
               if (op == OP_ERASE && $urandom_range(0, 3) != 0)
                  val = pool_value($urandom_range(0, 5));
               ops_made++;
            end
            row.req.req_type = op;
            row.req.value    = val;
            stim_add(row);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (sent_count < stim_rows.size()) @(posedge clock);
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d transactions: %0d pushes, %0d pops, %0d erases, %0d unused codes",
               sent_count, n_push, n_pop, n_erase, n_unused);
      $display("%0d overflows, %0d underflows, %0d entries removed, peak fill %0d of %0d",
               n_overflow, n_underflow, n_removed, peak_held, DEPTH);
      if (mismatches == 0) begin
         $display("deque_with_erase_by_value_test: clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("deque_with_erase_by_value_test: errors");
      end
      $finish;
   end

endmodule

### files.f
rtl/dqe_pkg.sv
rtl/dqe_ram.sv
rtl/dqe_ctrl.sv
rtl/dqe_dp.sv
rtl/deque_with_erase_by_value.sv
rtl/dqe_checker.sv
sim/deque_with_erase_by_value_test.sv
